@@ sv/atc_pkg.sv @@
// atc_pkg: shared codes, control word type and microprogram for the text terminal cursor
package atc_pkg;

  // microprogram counter width and addresses
  localparam int unsigned UPC_W = 5;
  localparam logic [UPC_W-1:0] U_IDLE      = 5'd0;
  localparam logic [UPC_W-1:0] U_DISPATCH  = 5'd1;
  localparam logic [UPC_W-1:0] U_ESC       = 5'd2;
  localparam logic [UPC_W-1:0] U_ESC1      = 5'd3;
  localparam logic [UPC_W-1:0] U_DIGIT     = 5'd4;
  localparam logic [UPC_W-1:0] U_SEMI      = 5'd5;
  localparam logic [UPC_W-1:0] U_SGR_INIT  = 5'd6;
  localparam logic [UPC_W-1:0] U_SGR_STEP  = 5'd7;
  localparam logic [UPC_W-1:0] U_SEQ_END   = 5'd8;
  localparam logic [UPC_W-1:0] U_LF        = 5'd9;
  localparam logic [UPC_W-1:0] U_NL_FILL   = 5'd10;
  localparam logic [UPC_W-1:0] U_NL_SCROLL = 5'd11;
  localparam logic [UPC_W-1:0] U_CR        = 5'd12;
  localparam logic [UPC_W-1:0] U_BS        = 5'd13;
  localparam logic [UPC_W-1:0] U_BS_FILL   = 5'd14;
  localparam logic [UPC_W-1:0] U_PR_BG     = 5'd15;
  localparam logic [UPC_W-1:0] U_PR_GLYPH  = 5'd16;
  localparam logic [UPC_W-1:0] U_PR_ADV    = 5'd17;

  // emit field of the control word
  localparam logic [2:0] EM_NONE       = 3'd0;
  localparam logic [2:0] EM_CELL_BLACK = 3'd1;
  localparam logic [2:0] EM_CELL_BG    = 3'd2;
  localparam logic [2:0] EM_GLYPH      = 3'd3;
  localparam logic [2:0] EM_ROW        = 3'd4;
  localparam logic [2:0] EM_SCROLL     = 3'd5;

  // datapath action field
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_ESC      = 4'd1;
  localparam logic [3:0] ACT_ESC1     = 4'd2;
  localparam logic [3:0] ACT_DIGIT    = 4'd3;
  localparam logic [3:0] ACT_SEMI     = 4'd4;
  localparam logic [3:0] ACT_SGR_INIT = 4'd5;
  localparam logic [3:0] ACT_SGR_STEP = 4'd6;
  localparam logic [3:0] ACT_SEQ_END  = 4'd7;
  localparam logic [3:0] ACT_NL_Y     = 4'd8;
  localparam logic [3:0] ACT_CR       = 4'd9;
  localparam logic [3:0] ACT_BS       = 4'd10;
  localparam logic [3:0] ACT_ADV      = 4'd11;

  // sequencing field
  localparam logic [2:0] J_NEXT     = 3'd0;
  localparam logic [2:0] J_GOTO     = 3'd1;
  localparam logic [2:0] J_FETCH    = 3'd2;
  localparam logic [2:0] J_DISPATCH = 3'd3;
  localparam logic [2:0] J_LOOP     = 3'd4;
  localparam logic [2:0] J_WRAP     = 3'd5;

  // last-flag field
  localparam logic [1:0] LAST_NO     = 2'd0;
  localparam logic [1:0] LAST_YES    = 2'd1;
  localparam logic [1:0] LAST_NOWRAP = 2'd2;

  // command kinds
  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_GLYPH  = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;

  // escape parser modes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_CSI  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CHAR_WIDTH    = 3'd0;
  localparam logic [2:0] REG_CHAR_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_WRAP_EN       = 3'd4;
  localparam logic [2:0] REG_HW_SCROLL_EN  = 3'd5;
  localparam logic [2:0] REG_SCALE_X       = 3'd6;
  localparam logic [2:0] REG_SCALE_Y       = 3'd7;

  // character codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_M        = 8'h6d;

  // sgr parameter codes and limits
  localparam logic [9:0] SGR_RESET   = 10'd0;
  localparam logic [9:0] SGR_BOLD    = 10'd1;
  localparam logic [9:0] SGR_FG_BASE = 10'd30;
  localparam logic [9:0] SGR_FG_END  = 10'd38;
  localparam logic [9:0] SGR_BG_BASE = 10'd40;
  localparam logic [9:0] SGR_BG_END  = 10'd48;
  localparam logic [9:0] PARAM_MAX   = 10'd1023;

  localparam logic [15:0] COLOR_WHITE = 16'hffff;
  localparam logic [15:0] COLOR_BLACK = 16'h0000;

  typedef struct packed {
    logic [2:0]       emit;
    logic [3:0]       act;
    logic [2:0]       jmp;
    logic [1:0]       last;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // eight-entry colour palette
  function automatic logic [15:0] sgr_palette(input logic [2:0] idx);
    logic [15:0] c;
    begin
      case (idx)
        3'd0:    c = 16'h0000;
        3'd1:    c = 16'hf800;
        3'd2:    c = 16'h0780;
        3'd3:    c = 16'hfe00;
        3'd4:    c = 16'h001f;
        3'd5:    c = 16'hf81f;
        3'd6:    c = 16'h07ff;
        default: c = 16'hffff;
      endcase
      return c;
    end
  endfunction

  function automatic ucode_t uc(input logic [2:0] em, input logic [3:0] act,
                                input logic [2:0] jmp, input logic [1:0] last,
                                input logic [UPC_W-1:0] tgt);
    ucode_t w;
    begin
      w.emit   = em;
      w.act    = act;
      w.jmp    = jmp;
      w.last   = last;
      w.target = tgt;
      return w;
    end
  endfunction

  // control store
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    begin
      unique case (addr)
        U_IDLE:      w = uc(EM_NONE, ACT_NONE, J_FETCH, LAST_NO, U_DISPATCH);
        U_DISPATCH:  w = uc(EM_NONE, ACT_NONE, J_DISPATCH, LAST_NO, U_IDLE);
        U_ESC:       w = uc(EM_NONE, ACT_ESC, J_GOTO, LAST_NO, U_IDLE);
        U_ESC1:      w = uc(EM_NONE, ACT_ESC1, J_GOTO, LAST_NO, U_IDLE);
        U_DIGIT:     w = uc(EM_NONE, ACT_DIGIT, J_GOTO, LAST_NO, U_IDLE);
        U_SEMI:      w = uc(EM_NONE, ACT_SEMI, J_GOTO, LAST_NO, U_IDLE);
        U_SGR_INIT:  w = uc(EM_NONE, ACT_SGR_INIT, J_NEXT, LAST_NO, U_IDLE);
        U_SGR_STEP:  w = uc(EM_NONE, ACT_SGR_STEP, J_LOOP, LAST_NO, U_SGR_STEP);
        U_SEQ_END:   w = uc(EM_NONE, ACT_SEQ_END, J_GOTO, LAST_NO, U_IDLE);
        U_LF:        w = uc(EM_NONE, ACT_NL_Y, J_NEXT, LAST_NO, U_IDLE);
        U_NL_FILL:   w = uc(EM_ROW, ACT_NONE, J_NEXT, LAST_NO, U_IDLE);
        U_NL_SCROLL: w = uc(EM_SCROLL, ACT_NONE, J_GOTO, LAST_YES, U_IDLE);
        U_CR:        w = uc(EM_NONE, ACT_CR, J_GOTO, LAST_NO, U_IDLE);
        U_BS:        w = uc(EM_NONE, ACT_BS, J_NEXT, LAST_NO, U_IDLE);
        U_BS_FILL:   w = uc(EM_CELL_BLACK, ACT_NONE, J_GOTO, LAST_YES, U_IDLE);
        U_PR_BG:     w = uc(EM_CELL_BG, ACT_NONE, J_NEXT, LAST_NO, U_IDLE);
        U_PR_GLYPH:  w = uc(EM_GLYPH, ACT_NONE, J_NEXT, LAST_NOWRAP, U_IDLE);
        U_PR_ADV:    w = uc(EM_NONE, ACT_ADV, J_WRAP, LAST_NO, U_LF);
        default:     w = uc(EM_NONE, ACT_NONE, J_GOTO, LAST_NO, U_IDLE);
      endcase
      return w;
    end
  endfunction

endpackage

@@ sv/ansi_text_terminal_cursor.sv @@
// ansi_text_terminal_cursor: microcoded text terminal cursor and display command generator
//
// Character bytes come in on the char channel (valid/ready), one per transfer.
// Each byte moves the cursor or the escape parser and gives zero to four
// display commands on the cmd channel (valid/ready); last_o marks the final
// command of a byte. Configuration registers are written through the cfg
// channel, which is always ready; write them only while the block is idle.
// A byte is taken when the sequencer sits at its idle step. For the SGR
// terminator the sequencer walks the stored parameters, up to MAX_PARAMS
// of them, one per cycle. One output register holds a command; a step that
// emits waits while that register is full and not being taken, so a stalled
// receiver holds back the sequencer but never loses or repeats a command.
// Reset returns the cursor to the origin, leaves text mode, clears all
// parameters and restores white on black, no bold and the default geometry.
module ansi_text_terminal_cursor #(
  parameter int unsigned MAX_PARAMS = 10,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input
  input  logic        char_valid_i,
  output logic        char_ready_o,
  input  logic [7:0]  char_byte_i,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // display commands
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output logic [1:0]  cmd_kind_o,
  output logic [11:0] pos_x_o,
  output logic [11:0] pos_y_o,
  output logic [11:0] rect_w_o,
  output logic [11:0] rect_h_o,
  output logic [15:0] color_o,
  output logic [6:0]  glyph_code_o,
  output logic        bold_flag_o,
  output logic [15:0] scroll_start_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned SUM_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
  localparam logic [SUM_W-1:0] COORD_MAX = SUM_W'((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_PARAMS - 1);

  // configuration registers
  logic [4:0]  char_width_q, char_height_q;
  logic [11:0] screen_width_q, screen_height_q;
  logic        wrap_en_q, hw_scroll_en_q;
  logic [3:0]  scale_x_q, scale_y_q;

  // terminal state
  logic [CW-1:0]    cursor_x_q, cursor_y_q;
  logic [1:0]       mode_q;
  logic [IDX_W-1:0] param_count_q;
  logic [IDX_W-1:0] walk_q;
  logic [9:0]       param_q [MAX_PARAMS];
  logic [15:0]      fg_color_q, bg_color_q;
  logic             bold_q;
  logic [7:0]       byte_q;

  // sequencer
  logic [atc_pkg::UPC_W-1:0] upc_q, upc_d;
  atc_pkg::ucode_t           uw;

  // output register
  logic        cmd_valid_q;
  logic [1:0]  cmd_kind_q;
  logic [11:0] pos_x_q, pos_y_q, rect_w_q, rect_h_q;
  logic [15:0] color_q, scroll_start_q;
  logic [6:0]  glyph_code_q;
  logic        bold_flag_q, last_q;

  // datapath signals
  logic [8:0]        cellw, cellh;
  logic [SUM_W-1:0]  x_ext, y_ext, x_sum, x_adv, ny_raw, ny, cellw_ext, cellh_ext;
  logic              draw_ok, bg_cond, wrap_nl;
  logic [IDX_W-1:0]  rd_idx;
  logic [9:0]        param_rd;
  logic [13:0]       dig_sum;
  logic [9:0]        dig_val;
  logic [9:0]        fg_off, bg_off;
  logic              emit_req, out_free, step_ok, emit_fire;
  logic [atc_pkg::UPC_W-1:0] dispatch_addr;
  logic [1:0]  n_kind;
  logic [11:0] n_px, n_py, n_w, n_h;
  logic [15:0] n_col, n_ss;
  logic [6:0]  n_code;
  logic        n_bold, n_last;

  assign uw          = atc_pkg::ucode_rom(upc_q);
  assign char_ready_o = (upc_q == atc_pkg::U_IDLE);
  assign cfg_ready_o  = 1'b1;

  // cell geometry
  assign cellw     = 9'(char_width_q) * 9'(scale_x_q);
  assign cellh     = 9'(char_height_q) * 9'(scale_y_q);
  assign cellw_ext = SUM_W'(cellw);
  assign cellh_ext = SUM_W'(cellh);
  assign x_ext     = SUM_W'(cursor_x_q);
  assign y_ext     = SUM_W'(cursor_y_q);

  // cursor advance with saturation and wrap test
  assign x_sum   = x_ext + cellw_ext;
  assign x_adv   = (x_sum > COORD_MAX) ? COORD_MAX : x_sum;
  assign wrap_nl = wrap_en_q && (x_adv >= SUM_W'(screen_width_q));

  // next row position
  assign ny_raw = y_ext + cellh_ext;
  always_comb begin
    if ((ny_raw + SUM_W'(char_height_q)) > SUM_W'(screen_height_q)) begin
      ny = '0;
    end else if (ny_raw > COORD_MAX) begin
      ny = COORD_MAX;
    end else begin
      ny = ny_raw;
    end
  end

  // glyph visibility and background fill
  assign draw_ok = (x_ext < SUM_W'(screen_width_q)) && (y_ext < SUM_W'(screen_height_q)) &&
                   ((cursor_x_q != '0) || (cellw != '0)) &&
                   ((cursor_y_q != '0) || (cellh != '0)) && !byte_q[7];
  assign bg_cond = (bg_color_q != atc_pkg::COLOR_BLACK) && (bg_color_q != fg_color_q);

  // parameter read port and digit accumulation
  assign rd_idx   = (upc_q == atc_pkg::U_DIGIT) ? param_count_q : walk_q;
  assign param_rd = param_q[rd_idx];
  assign dig_sum  = 14'(param_rd) * 14'd10 + 14'(byte_q[3:0]);
  assign dig_val  = (dig_sum > 14'(atc_pkg::PARAM_MAX)) ? atc_pkg::PARAM_MAX : dig_sum[9:0];
  assign fg_off   = param_rd - atc_pkg::SGR_FG_BASE;
  assign bg_off   = param_rd - atc_pkg::SGR_BG_BASE;

  // byte classification for the dispatch jump
  always_comb begin
    if (byte_q == atc_pkg::CH_ESC) begin
      dispatch_addr = atc_pkg::U_ESC;
    end else if (mode_q == atc_pkg::MODE_ESC) begin
      dispatch_addr = atc_pkg::U_ESC1;
    end else if (mode_q != atc_pkg::MODE_TEXT) begin
      if ((byte_q >= atc_pkg::CH_ZERO) && (byte_q <= atc_pkg::CH_NINE)) begin
        dispatch_addr = atc_pkg::U_DIGIT;
      end else if (byte_q == atc_pkg::CH_SEMI) begin
        dispatch_addr = atc_pkg::U_SEMI;
      end else if (byte_q == atc_pkg::CH_M) begin
        dispatch_addr = atc_pkg::U_SGR_INIT;
      end else begin
        dispatch_addr = atc_pkg::U_SEQ_END;
      end
    end else if (byte_q == atc_pkg::CH_LF) begin
      dispatch_addr = atc_pkg::U_LF;
    end else if (byte_q == atc_pkg::CH_CR) begin
      dispatch_addr = atc_pkg::U_CR;
    end else if (byte_q == atc_pkg::CH_BS) begin
      dispatch_addr = atc_pkg::U_BS;
    end else begin
      dispatch_addr = atc_pkg::U_PR_BG;
    end
  end

  // emit request and stall
  always_comb begin
    unique case (uw.emit)
      atc_pkg::EM_NONE:       emit_req = 1'b0;
      atc_pkg::EM_CELL_BG:    emit_req = draw_ok && bg_cond;
      atc_pkg::EM_GLYPH:      emit_req = draw_ok;
      default:                emit_req = 1'b1;
    endcase
  end
  assign out_free  = !cmd_valid_q || cmd_ready_i;
  assign emit_fire = emit_req && out_free;
  assign step_ok   = !emit_req || out_free;

  // command fields for the current emit step
  always_comb begin
    n_kind = atc_pkg::KIND_FILL;
    n_px   = 12'(cursor_x_q);
    n_py   = 12'(cursor_y_q);
    n_w    = 12'(cellw);
    n_h    = 12'(cellh);
    n_col  = atc_pkg::COLOR_BLACK;
    n_code = '0;
    n_bold = 1'b0;
    n_ss   = '0;
    unique case (uw.emit)
      atc_pkg::EM_CELL_BG: begin
        n_col = bg_color_q;
      end
      atc_pkg::EM_GLYPH: begin
        n_kind = atc_pkg::KIND_GLYPH;
        n_col  = fg_color_q;
        n_code = byte_q[6:0];
        n_bold = bold_q;
      end
      atc_pkg::EM_ROW: begin
        n_px = '0;
        n_w  = screen_width_q;
      end
      atc_pkg::EM_SCROLL: begin
        n_kind = atc_pkg::KIND_SCROLL;
        n_px   = '0;
        n_py   = '0;
        n_w    = '0;
        n_h    = '0;
        if (hw_scroll_en_q) begin
          n_ss = 16'(screen_height_q) - 16'(cursor_y_q) - 16'(cellh);
        end
      end
      default: begin
      end
    endcase
    unique case (uw.last)
      atc_pkg::LAST_YES:    n_last = 1'b1;
      atc_pkg::LAST_NOWRAP: n_last = !wrap_nl;
      default:              n_last = 1'b0;
    endcase
  end

  // next step selection
  always_comb begin
    upc_d = upc_q;
    if (step_ok) begin
      unique case (uw.jmp)
        atc_pkg::J_NEXT:     upc_d = upc_q + 1'b1;
        atc_pkg::J_GOTO:     upc_d = uw.target;
        atc_pkg::J_FETCH:    upc_d = char_valid_i ? uw.target : upc_q;
        atc_pkg::J_DISPATCH: upc_d = dispatch_addr;
        atc_pkg::J_LOOP:     upc_d = (walk_q != param_count_q) ? uw.target : upc_q + 1'b1;
        atc_pkg::J_WRAP:     upc_d = wrap_nl ? uw.target : atc_pkg::U_IDLE;
        default:             upc_d = atc_pkg::U_IDLE;
      endcase
    end
  end

  // sequencer register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= atc_pkg::U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // byte capture on input transfer
  always_ff @(posedge clk_i) begin
    if (char_valid_i && char_ready_o) begin
      byte_q <= char_byte_i;
    end
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_width_q    <= 5'd7;
      char_height_q   <= 5'd10;
      screen_width_q  <= 12'd240;
      screen_height_q <= 12'd320;
      wrap_en_q       <= 1'b0;
      hw_scroll_en_q  <= 1'b0;
      scale_x_q       <= 4'd1;
      scale_y_q       <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        atc_pkg::REG_CHAR_WIDTH:    char_width_q    <= cfg_data_i[4:0];
        atc_pkg::REG_CHAR_HEIGHT:   char_height_q   <= cfg_data_i[4:0];
        atc_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        atc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        atc_pkg::REG_WRAP_EN:       wrap_en_q       <= cfg_data_i[0];
        atc_pkg::REG_HW_SCROLL_EN:  hw_scroll_en_q  <= cfg_data_i[0];
        atc_pkg::REG_SCALE_X:       scale_x_q       <= cfg_data_i[3:0];
        atc_pkg::REG_SCALE_Y:       scale_y_q       <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // datapath actions of the current step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q    <= '0;
      cursor_y_q    <= '0;
      mode_q        <= atc_pkg::MODE_TEXT;
      param_count_q <= '0;
      walk_q        <= '0;
      fg_color_q    <= atc_pkg::COLOR_WHITE;
      bg_color_q    <= atc_pkg::COLOR_BLACK;
      bold_q        <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        param_q[i] <= '0;
      end
    end else begin
      case (uw.act)
        atc_pkg::ACT_ESC: begin
          mode_q <= atc_pkg::MODE_ESC;
        end
        atc_pkg::ACT_ESC1: begin
          if (byte_q == atc_pkg::CH_LBRACKET) begin
            mode_q        <= atc_pkg::MODE_CSI;
            param_count_q <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
              param_q[i] <= '0;
            end
          end else begin
            mode_q <= atc_pkg::MODE_TEXT;
          end
        end
        atc_pkg::ACT_DIGIT: begin
          param_q[param_count_q] <= dig_val;
        end
        atc_pkg::ACT_SEMI: begin
          if (param_count_q != LAST_IDX) begin
            param_count_q <= param_count_q + 1'b1;
          end
        end
        atc_pkg::ACT_SGR_INIT: begin
          walk_q <= '0;
        end
        atc_pkg::ACT_SGR_STEP: begin
          walk_q <= walk_q + 1'b1;
          if (param_rd == atc_pkg::SGR_RESET) begin
            if (param_count_q == '0) begin
              fg_color_q <= atc_pkg::COLOR_WHITE;
              bg_color_q <= atc_pkg::COLOR_BLACK;
            end
            bold_q <= 1'b0;
          end else if (param_rd == atc_pkg::SGR_BOLD) begin
            bold_q <= 1'b1;
          end else if ((param_rd >= atc_pkg::SGR_FG_BASE) &&
                       (param_rd < atc_pkg::SGR_FG_END)) begin
            fg_color_q <= atc_pkg::sgr_palette(fg_off[2:0]);
          end else if ((param_rd >= atc_pkg::SGR_BG_BASE) &&
                       (param_rd < atc_pkg::SGR_BG_END)) begin
            bg_color_q <= atc_pkg::sgr_palette(bg_off[2:0]);
          end
        end
        atc_pkg::ACT_SEQ_END: begin
          mode_q        <= atc_pkg::MODE_TEXT;
          param_count_q <= '0;
          for (int i = 0; i < MAX_PARAMS; i++) begin
            param_q[i] <= '0;
          end
        end
        atc_pkg::ACT_NL_Y: begin
          cursor_x_q <= '0;
          cursor_y_q <= ny[CW-1:0];
        end
        atc_pkg::ACT_CR: begin
          cursor_x_q <= '0;
        end
        atc_pkg::ACT_BS: begin
          if (cursor_x_q != '0) begin
            if (x_ext > cellw_ext) begin
              cursor_x_q <= CW'(x_ext - cellw_ext);
            end else begin
              cursor_x_q <= '0;
            end
          end
        end
        atc_pkg::ACT_ADV: begin
          cursor_x_q <= x_adv[CW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (emit_fire) begin
      cmd_valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      cmd_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      cmd_kind_q     <= n_kind;
      pos_x_q        <= n_px;
      pos_y_q        <= n_py;
      rect_w_q       <= n_w;
      rect_h_q       <= n_h;
      color_q        <= n_col;
      glyph_code_q   <= n_code;
      bold_flag_q    <= n_bold;
      scroll_start_q <= n_ss;
      last_q         <= n_last;
    end
  end

  assign cmd_valid_o    = cmd_valid_q;
  assign cmd_kind_o     = cmd_kind_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign rect_w_o       = rect_w_q;
  assign rect_h_o       = rect_h_q;
  assign color_o        = color_q;
  assign glyph_code_o   = glyph_code_q;
  assign bold_flag_o    = bold_flag_q;
  assign scroll_start_o = scroll_start_q;
  assign last_o         = last_q;

endmodule

@@ tb/tb_ansi_text_terminal_cursor.sv @@
// tb_ansi_text_terminal_cursor: self-checking bench with a command scoreboard for the text terminal
module tb_ansi_text_terminal_cursor;

  localparam int unsigned PARAM_SLOTS   = 10;
  localparam int unsigned COORD_MAX     = 4095;
  localparam int unsigned GLYPH_LIMIT   = 128;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned STALL_LIMIT   = 2000;

  localparam logic [15:0] SGR_COLOURS [8] = '{16'h0000, 16'hf800, 16'h0780, 16'hfe00,
                                              16'h001f, 16'hf81f, 16'h07ff, 16'hffff};

  typedef struct packed {
    logic [1:0]  cmd_kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [15:0] color;
    logic [6:0]  glyph_code;
    logic        bold_flag;
    logic [15:0] scroll_start;
    logic        last;
  } disp_cmd_t;

  // predicts display commands per accepted byte and checks the command stream
  class cmd_scoreboard;
    int unsigned char_w, char_h, scr_w, scr_h, zoom_x, zoom_y;
    bit          wrap_en, hw_scroll;
    int unsigned cur_x, cur_y, n_params;
    int unsigned params [PARAM_SLOTS];
    logic [1:0]  mode;
    logic [15:0] fg, bg;
    bit          bold_on;
    disp_cmd_t   pending_cmds [$];
    disp_cmd_t   byte_cmds [$];
    int unsigned errors, bytes_seen, cmds_seen;

    function new();
      char_w    = 7;
      char_h    = 10;
      scr_w     = 240;
      scr_h     = 320;
      wrap_en   = 1'b0;
      hw_scroll = 1'b0;
      zoom_x    = 1;
      zoom_y    = 1;
      cur_x     = 0;
      cur_y     = 0;
      mode      = atc_pkg::MODE_TEXT;
      fg        = atc_pkg::COLOR_WHITE;
      bg        = atc_pkg::COLOR_BLACK;
      bold_on   = 1'b0;
      clear_params();
    endfunction

    function void clear_params();
      foreach (params[i]) params[i] = 0;
      n_params = 0;
    endfunction

    function int unsigned pending();
      return pending_cmds.size();
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [11:0] data);
      case (idx)
        atc_pkg::REG_CHAR_WIDTH:    char_w    = data[4:0];
        atc_pkg::REG_CHAR_HEIGHT:   char_h    = data[4:0];
        atc_pkg::REG_SCREEN_WIDTH:  scr_w     = data;
        atc_pkg::REG_SCREEN_HEIGHT: scr_h     = data;
        atc_pkg::REG_WRAP_EN:       wrap_en   = data[0];
        atc_pkg::REG_HW_SCROLL_EN:  hw_scroll = data[0];
        atc_pkg::REG_SCALE_X:       zoom_x    = data[3:0];
        atc_pkg::REG_SCALE_Y:       zoom_y    = data[3:0];
        default: ;
      endcase
    endfunction

    function void add_cmd(input logic [1:0] kind, input int unsigned x, input int unsigned y,
                          input int unsigned w, input int unsigned h,
                          input logic [15:0] colour, input logic [6:0] code,
                          input logic bold_bit, input logic [15:0] start);
      disp_cmd_t c;
      c.cmd_kind     = kind;
      c.pos_x        = 12'(x);
      c.pos_y        = 12'(y);
      c.rect_w       = 12'(w);
      c.rect_h       = 12'(h);
      c.color        = colour;
      c.glyph_code   = code;
      c.bold_flag    = bold_bit;
      c.scroll_start = start;
      c.last         = 1'b0;
      byte_cmds.push_back(c);
    endfunction

    // next row: clear it, then move the scroll start
    function void new_line();
      int unsigned cellh, ny, ss;
      cellh = char_h * zoom_y;
      ny    = cur_y + cellh;
      ss    = 0;
      cur_x = 0;
      if (ny + char_h > scr_h) ny = 0;
      if (ny > COORD_MAX) ny = COORD_MAX;
      cur_y = ny;
      add_cmd(atc_pkg::KIND_FILL, 0, ny, scr_w, cellh, atc_pkg::COLOR_BLACK, '0, 1'b0, '0);
      if (hw_scroll) ss = scr_h - ny - cellh;
      add_cmd(atc_pkg::KIND_SCROLL, 0, 0, 0, 0, atc_pkg::COLOR_BLACK, '0, 1'b0, 16'(ss));
    endfunction

    function void apply_sgr();
      int unsigned n, v;
      n = n_params + 1;
      for (int unsigned i = 0; i < n && i < PARAM_SLOTS; i++) begin
        v = params[i];
        if (v == atc_pkg::SGR_RESET) begin
          if (n == 1) begin
            fg = atc_pkg::COLOR_WHITE;
            bg = atc_pkg::COLOR_BLACK;
          end
          bold_on = 1'b0;
        end else if (v == atc_pkg::SGR_BOLD) begin
          bold_on = 1'b1;
        end else if (v >= atc_pkg::SGR_FG_BASE && v < atc_pkg::SGR_FG_END) begin
          fg = SGR_COLOURS[v - atc_pkg::SGR_FG_BASE];
        end else if (v >= atc_pkg::SGR_BG_BASE && v < atc_pkg::SGR_BG_END) begin
          bg = SGR_COLOURS[v - atc_pkg::SGR_BG_BASE];
        end
      end
    endfunction

    // accepted byte: advance the parser and cursor, queue the commands it causes
    function void note_byte(input logic [7:0] b);
      int unsigned cellw, cellh, slot, v;
      bytes_seen++;
      cellw = char_w * zoom_x;
      cellh = char_h * zoom_y;
      byte_cmds.delete();
      if (b == atc_pkg::CH_ESC) begin
        mode = atc_pkg::MODE_ESC;
        return;
      end
      if (mode == atc_pkg::MODE_ESC) begin
        if (b == atc_pkg::CH_LBRACKET) begin
          mode = atc_pkg::MODE_CSI;
          clear_params();
        end else begin
          mode = atc_pkg::MODE_TEXT;
        end
        return;
      end
      if (mode != atc_pkg::MODE_TEXT) begin
        slot = (n_params < PARAM_SLOTS) ? n_params : PARAM_SLOTS - 1;
        if (b >= atc_pkg::CH_ZERO && b <= atc_pkg::CH_NINE) begin
          v = params[slot] * 10 + (b - atc_pkg::CH_ZERO);
          params[slot] = (v > atc_pkg::PARAM_MAX) ? atc_pkg::PARAM_MAX : v;
        end else if (b == atc_pkg::CH_SEMI) begin
          if (n_params < PARAM_SLOTS - 1) n_params++;
        end else begin
          if (b == atc_pkg::CH_M) apply_sgr();
          mode = atc_pkg::MODE_TEXT;
          clear_params();
        end
        return;
      end
      if (b == atc_pkg::CH_LF) begin
        new_line();
      end else if (b == atc_pkg::CH_CR) begin
        cur_x = 0;
      end else if (b == atc_pkg::CH_BS) begin
        if (cur_x > 0) cur_x = (cur_x > cellw) ? cur_x - cellw : 0;
        add_cmd(atc_pkg::KIND_FILL, cur_x, cur_y, cellw, cellh, atc_pkg::COLOR_BLACK,
                '0, 1'b0, '0);
      end else begin
        if (cur_x < scr_w && cur_y < scr_h && cur_x + cellw != 0 && cur_y + cellh != 0 &&
            b < GLYPH_LIMIT) begin
          if (bg != atc_pkg::COLOR_BLACK && bg != fg)
            add_cmd(atc_pkg::KIND_FILL, cur_x, cur_y, cellw, cellh, bg, '0, 1'b0, '0);
          add_cmd(atc_pkg::KIND_GLYPH, cur_x, cur_y, cellw, cellh, fg, b[6:0], bold_on, '0);
        end
        cur_x += cellw;
        if (cur_x > COORD_MAX) cur_x = COORD_MAX;
        if (cur_x >= scr_w && wrap_en) new_line();
      end
      if (byte_cmds.size() != 0) byte_cmds[byte_cmds.size() - 1].last = 1'b1;
      foreach (byte_cmds[i]) pending_cmds.push_back(byte_cmds[i]);
    endfunction

    function void compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    // accepted command against the oldest prediction
    function void check_cmd(input disp_cmd_t got);
      disp_cmd_t want;
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        $error("cmd_kind: expected no command, got kind %0d", got.cmd_kind);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      compare_field("cmd_kind", want.cmd_kind, got.cmd_kind);
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("rect_w", want.rect_w, got.rect_w);
      compare_field("rect_h", want.rect_h, got.rect_h);
      compare_field("color", want.color, got.color);
      compare_field("glyph_code", want.glyph_code, got.glyph_code);
      compare_field("bold_flag", want.bold_flag, got.bold_flag);
      compare_field("scroll_start", want.scroll_start, got.scroll_start);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        char_valid_i = 1'b0;
  logic        char_ready_o;
  logic [7:0]  char_byte_i  = '0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i  = '0;
  logic [11:0] cfg_data_i   = '0;
  logic        cmd_valid_o;
  logic        cmd_ready_i  = 1'b0;
  logic [1:0]  cmd_kind_o;
  logic [11:0] pos_x_o, pos_y_o, rect_w_o, rect_h_o;
  logic [15:0] color_o;
  logic [6:0]  glyph_code_o;
  logic        bold_flag_o;
  logic [15:0] scroll_start_o;
  logic        last_o;

  disp_cmd_t      seen_cmd;
  cmd_scoreboard  sb = new();
  logic           calm = 1'b0;
  int unsigned    bytes_sent = 0;
  int unsigned    settings_loaded = 0;
  int unsigned    quiet_cycles = 0;

  ansi_text_terminal_cursor #(
    .MAX_PARAMS(PARAM_SLOTS),
    .COORD_BITS(12)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_valid_i  (char_valid_i),
    .char_ready_o  (char_ready_o),
    .char_byte_i   (char_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_valid_o   (cmd_valid_o),
    .cmd_ready_i   (cmd_ready_i),
    .cmd_kind_o    (cmd_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .rect_w_o      (rect_w_o),
    .rect_h_o      (rect_h_o),
    .color_o       (color_o),
    .glyph_code_o  (glyph_code_o),
    .bold_flag_o   (bold_flag_o),
    .scroll_start_o(scroll_start_o),
    .last_o        (last_o)
  );

  assign seen_cmd = {cmd_kind_o, pos_x_o, pos_y_o, rect_w_o, rect_h_o, color_o,
                     glyph_code_o, bold_flag_o, scroll_start_o, last_o};

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // command receiver with random back-pressure
  always @(posedge clk_i)
    cmd_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);

  // transfer monitor feeding the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (char_valid_i && char_ready_o) sb.note_byte(char_byte_i);
      if (cmd_valid_o && cmd_ready_i) sb.check_cmd(seen_cmd);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (char_valid_i && char_ready_o) || (cmd_valid_o && cmd_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        char_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    char_valid_i <= 1'b1;
    char_byte_i  <= b;
    do @(posedge clk_i); while (!char_ready_o);
    bytes_sent++;
  endtask

  task automatic send_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // stop sending, let every command out and give the sequencer time to finish
  task automatic wait_idle();
    char_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_geometry(input int unsigned cw, input int unsigned ch,
                               input int unsigned sw, input int unsigned sh,
                               input int unsigned wrap, input int unsigned hws,
                               input int unsigned sx, input int unsigned sy);
    logic [11:0] vals [8];
    logic [2:0]  idx;
    vals[atc_pkg::REG_CHAR_WIDTH]    = 12'(cw);
    vals[atc_pkg::REG_CHAR_HEIGHT]   = 12'(ch);
    vals[atc_pkg::REG_SCREEN_WIDTH]  = 12'(sw);
    vals[atc_pkg::REG_SCREEN_HEIGHT] = 12'(sh);
    vals[atc_pkg::REG_WRAP_EN]       = 12'(wrap);
    vals[atc_pkg::REG_HW_SCROLL_EN]  = 12'(hws);
    vals[atc_pkg::REG_SCALE_X]       = 12'(sx);
    vals[atc_pkg::REG_SCALE_Y]       = 12'(sy);
    for (int r = 0; r < 8; r++) begin
      idx = 3'(r);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  function automatic int unsigned pick_sgr_code();
    case ($urandom_range(9))
      0:       return atc_pkg::SGR_RESET;
      1:       return atc_pkg::SGR_BOLD;
      2, 3, 4: return atc_pkg::SGR_FG_BASE + $urandom_range(7);
      5, 6, 7: return atc_pkg::SGR_BG_BASE + $urandom_range(7);
      // just past either colour range
      8:       return ($urandom_range(1) ? atc_pkg::SGR_FG_END : atc_pkg::SGR_BG_END) +
                      $urandom_range(1);
      default: return $urandom_range(atc_pkg::PARAM_MAX);
    endcase
  endfunction

  task automatic send_sgr(input int unsigned n);
    send_char(atc_pkg::CH_ESC);
    send_char(atc_pkg::CH_LBRACKET);
    for (int unsigned k = 0; k < n; k++) begin
      if (k != 0) send_char(atc_pkg::CH_SEMI);
      send_number(pick_sgr_code());
    end
    send_char(atc_pkg::CH_M);
  endtask

  // malformed and limit-hitting escape sequences
  task automatic send_broken();
    logic [7:0] term;
    case ($urandom_range(4))
      0: begin
        send_char(atc_pkg::CH_ESC);
        send_char(8'($urandom_range(32, 126)));
      end
      1: begin
        term = 8'($urandom_range(64, 126));
        if (term == atc_pkg::CH_M) term = "H";
        send_char(atc_pkg::CH_ESC);
        send_char(atc_pkg::CH_LBRACKET);
        send_number($urandom_range(99));
        send_char(term);
      end
      2: begin
        send_char(atc_pkg::CH_ESC);
        send_char(atc_pkg::CH_LBRACKET);
        send_number($urandom_range(10000, 99999));
        send_char(atc_pkg::CH_M);
      end
      3: send_sgr($urandom_range(11, 13));
      default: begin
        send_char(atc_pkg::CH_ESC);
        send_char(atc_pkg::CH_LBRACKET);
        send_char(atc_pkg::CH_ZERO + 8'($urandom_range(9)));
        send_sgr(1);
      end
    endcase
  endtask

  // mostly text and well-formed sgr, some control bytes, noise and broken sequences
  task automatic send_random_stream(input int unsigned n_chars);
    int unsigned stop_at, pick, len;
    stop_at = bytes_sent + n_chars;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(1, 8);
        for (int unsigned k = 0; k < len; k++) send_char(8'($urandom_range(32, 126)));
      end else if (pick < 65) begin
        send_sgr($urandom_range(0, 4));
      end else if (pick < 77) begin
        case ($urandom_range(2))
          0:       send_char(atc_pkg::CH_LF);
          1:       send_char(atc_pkg::CH_CR);
          default: send_char(atc_pkg::CH_BS);
        endcase
      end else if (pick < 88) begin
        send_char(8'($urandom_range(255)));
      end else begin
        send_broken();
      end
    end
  endtask

  initial begin
    logic [7:0] opening [$];
    // glyph code extremes, a byte past the glyph range, backspace at column 0,
    // new line, background fill, bold with colour, attribute reset, dropped escape
    opening = '{"A", 8'h00, 8'h7f, 8'hff, atc_pkg::CH_BS, atc_pkg::CH_CR, atc_pkg::CH_BS,
                atc_pkg::CH_LF,
                atc_pkg::CH_ESC, atc_pkg::CH_LBRACKET, "4", "4", atc_pkg::CH_M, "Z",
                atc_pkg::CH_ESC, atc_pkg::CH_LBRACKET, "1", atc_pkg::CH_SEMI, "3", "1",
                atc_pkg::CH_M, "q",
                atc_pkg::CH_ESC, atc_pkg::CH_LBRACKET, atc_pkg::CH_M, atc_pkg::CH_ESC, "x"};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry
    foreach (opening[i]) send_char(opening[i]);
    send_random_stream(15);
    wait_idle();

    // large cells on the largest screen, wrap and hardware scroll, no idling
    calm <= 1'b1;
    load_geometry(16, 16, 4095, 4095, 1, 1, 8, 8);
    send_random_stream(15);
    wait_idle();
    calm <= 1'b0;

    // one-pixel cells on a one-pixel screen, no wrap
    load_geometry(1, 1, 1, 1, 0, 1, 1, 1);
    send_random_stream(12);
    wait_idle();

    // tall cells on a one-line screen: scroll start wraps below zero
    load_geometry(16, 16, 1, 1, 1, 1, 1, 8);
    send_random_stream(10);
    wait_idle();

    // random geometries, with a full drain in the middle of each
    repeat (2) begin
      load_geometry($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(8, 300),
                    $urandom_range(8, 300), $urandom_range(1), $urandom_range(1),
                    $urandom_range(1, 8), $urandom_range(1, 8));
      send_random_stream(7);
      char_valid_i <= 1'b0;
      wait_drained();
      send_random_stream(7);
      wait_idle();
    end

    if (sb.pending() != 0) begin
      $error("last: %0d commands never arrived", sb.pending());
      sb.errors++;
    end
    $display("run covered %0d bytes and %0d display commands", sb.bytes_seen, sb.cmds_seen);
    $display("across %0d register settings plus the reset geometry", settings_loaded);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/atc_pkg.sv
sv/ansi_text_terminal_cursor.sv
tb/tb_ansi_text_terminal_cursor.sv
